// ----- src/npc_pkg.sv -----
// Package for the nearest prototype classifier.
// Sizes, field widths and the control state type; no dependencies.
package npc_pkg;
    localparam int DIM = 64;
    localparam int PROTOS = 64;
    localparam int DW = $clog2(DIM);
    localparam int PW = $clog2(PROTOS);
    localparam int LW = $clog2(DIM + 1);
    localparam int CW = $clog2(PROTOS + 1);
    localparam int SW = 39;
    localparam int EW = 16;
    localparam int AW = PW + DW;
    localparam logic [SW-1:0] DIST_MAX = {SW{1'b1}};
    localparam logic [1:0] REG_LEN = 2'd0;
    localparam logic [1:0] REG_CAP = 2'd1;
    localparam logic [1:0] REG_THR = 2'd2;

    typedef enum logic [2:0] {
        S_COLLECT,
        S_SCAN,
        S_DRAIN,
        S_STORE,
        S_DONE
    } t_state;

    typedef struct packed {
        logic          clr;
        logic          acc;
        logic          last;
    } t_acc_ctl;
endpackage

// ----- src/npc_ram.sv -----
// Generic single-port-write, one-read synchronous RAM with registered read.
// No dependencies.
module npc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- src/npc_dist.sv -----
// Squared distance accumulator with saturation and best-slot tracking.
// Depends on npc_pkg.
module npc_dist (
    input  logic                      i_clk,
    input  npc_pkg::t_acc_ctl         i_ctl,
    input  logic signed [npc_pkg::EW-1:0] i_a,
    input  logic signed [npc_pkg::EW-1:0] i_b,
    input  logic [npc_pkg::PW-1:0]    i_slot,
    input  logic                      i_first,
    output logic [npc_pkg::SW-1:0]    o_best,
    output logic [npc_pkg::PW-1:0]    o_best_slot
);
    logic [npc_pkg::SW-1:0] r_sum, n_sum;
    logic [npc_pkg::SW-1:0] r_best;
    logic [npc_pkg::PW-1:0] r_best_slot;
    logic signed [npc_pkg::EW:0] w_d;
    logic [npc_pkg::EW:0] w_ad;
    logic [2*npc_pkg::EW+1:0] w_sq;
    logic [npc_pkg::SW:0] w_add;

    always_comb begin
        w_d = {i_a[npc_pkg::EW-1], i_a} - {i_b[npc_pkg::EW-1], i_b};
        w_ad = w_d[npc_pkg::EW] ? (npc_pkg::EW + 1)'(0) - w_d : w_d;
        w_sq = w_ad * w_ad;
        w_add = {1'b0, (i_ctl.clr ? '0 : r_sum)}
              + (npc_pkg::SW + 1)'(w_sq);
        n_sum = w_add[npc_pkg::SW] ? npc_pkg::DIST_MAX : w_add[npc_pkg::SW-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.acc) begin
            r_sum <= n_sum;
            if (i_ctl.last && (i_first || n_sum < r_best)) begin
                r_best <= n_sum;
                r_best_slot <= i_slot;
            end
        end
    end

    assign o_best = r_best;
    assign o_best_slot = r_best_slot;
endmodule

// ----- src/nearest_prototype_classifier.sv -----
// Top level of the nearest prototype classifier: control, registers, memories.
// Depends on npc_pkg, npc_ram and npc_dist.
//
//  channel | signals                                   | direction
//  in      | i_valid o_ready i_element i_last_element  | input transfer
//  out     | o_valid i_ready o_proto_index ...         | result transfer
//  cfg     | i_cfg_we i_cfg_index i_cfg_data           | register write
//
// After a last element the scan walks the prototype memory one element per
// cycle over every stored prototype, drains the pipeline, copies the vector
// when it is stored and then registers the result.
// Reset is synchronous and leaves the store empty; no clearing pass.
// Input is held off while a result waits on a stalled output.
module nearest_prototype_classifier (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [1:0]               i_cfg_index,
    input  logic [npc_pkg::SW-1:0]   i_cfg_data,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic signed [15:0]       i_element,
    input  logic                     i_last_element,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic [5:0]               o_proto_index,
    output logic                     o_new_proto,
    output logic [38:0]              o_match_distance_sq
);
    npc_pkg::t_state r_state, n_state;
    logic [6:0] r_len_reg, r_cap_reg;
    logic [npc_pkg::SW-1:0] r_thr;
    logic [npc_pkg::LW-1:0] w_len;
    logic [npc_pkg::CW-1:0] w_cap;
    logic [npc_pkg::CW-1:0] r_used;
    logic [npc_pkg::LW-1:0] r_ecnt;
    logic [npc_pkg::DW-1:0] r_i;
    logic [npc_pkg::PW-1:0] r_p;
    logic [npc_pkg::DW-1:0] r_i1;
    logic [npc_pkg::PW-1:0] r_p1;
    logic r_v1, n_v1, r_first1, r_last1;
    logic r_ok1;
    logic [5:0] r_oidx;
    logic r_onew;
    logic [npc_pkg::SW-1:0] r_odist;
    logic r_ovalid;

    logic vb_we, pm_we;
    logic [npc_pkg::DW-1:0] vb_waddr, vb_raddr;
    logic [npc_pkg::EW-1:0] vb_wdata, vb_rdata, pm_rdata;
    logic [npc_pkg::AW-1:0] pm_waddr, pm_raddr;
    logic [npc_pkg::EW-1:0] pm_wdata;
    npc_pkg::t_acc_ctl w_ctl;
    logic [npc_pkg::SW-1:0] w_best;
    logic [npc_pkg::PW-1:0] w_best_slot;
    logic w_in_fire, w_scan_end, w_ins;
    logic [npc_pkg::EW-1:0] w_a;

    always_comb begin
        if (r_len_reg == 7'd0) w_len = npc_pkg::LW'(1);
        else if (r_len_reg > 7'(npc_pkg::DIM)) w_len = npc_pkg::LW'(npc_pkg::DIM);
        else w_len = npc_pkg::LW'(r_len_reg);
        if (r_cap_reg == 7'd0) w_cap = npc_pkg::CW'(1);
        else if (r_cap_reg > 7'(npc_pkg::PROTOS)) w_cap = npc_pkg::CW'(npc_pkg::PROTOS);
        else w_cap = npc_pkg::CW'(r_cap_reg);
    end

    assign w_in_fire = i_valid && o_ready;
    assign w_scan_end = (r_i == npc_pkg::DW'(w_len - 1'b1))
                     && (npc_pkg::CW'(r_p) == r_used - 1'b1);
    assign w_ins = (r_used == '0)
                || (w_best > r_thr && r_used < w_cap
                    && r_used < npc_pkg::CW'(npc_pkg::PROTOS));

    npc_ram #(.WIDTH(npc_pkg::EW), .DEPTH(npc_pkg::DIM)) u_vbuf (
        .i_clk(i_clk), .i_we(vb_we), .i_waddr(vb_waddr), .i_wdata(vb_wdata),
        .i_raddr(vb_raddr), .o_rdata(vb_rdata)
    );
    npc_ram #(.WIDTH(npc_pkg::EW), .DEPTH(npc_pkg::DIM * npc_pkg::PROTOS)) u_store (
        .i_clk(i_clk), .i_we(pm_we), .i_waddr(pm_waddr), .i_wdata(pm_wdata),
        .i_raddr(pm_raddr), .o_rdata(pm_rdata)
    );

    // short vectors: positions past the received count read as zero
    assign w_a = r_ok1 ? vb_rdata : '0;

    npc_dist u_dist (
        .i_clk(i_clk), .i_ctl(w_ctl), .i_a(w_a), .i_b(pm_rdata),
        .i_slot(r_p1), .i_first(r_first1), .o_best(w_best), .o_best_slot(w_best_slot)
    );

    always_comb begin
        w_ctl.acc = r_v1 && (r_state != npc_pkg::S_STORE);
        w_ctl.clr = r_v1 && (r_i1 == '0);
        w_ctl.last = r_last1;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            npc_pkg::S_COLLECT:
                if (w_in_fire && i_last_element) begin
                    n_state = (r_used == '0) ? npc_pkg::S_STORE : npc_pkg::S_SCAN;
                end
            npc_pkg::S_SCAN:  if (w_scan_end) n_state = npc_pkg::S_DRAIN;
            npc_pkg::S_DRAIN: if (!r_v1) n_state = w_ins ? npc_pkg::S_STORE : npc_pkg::S_DONE;
            npc_pkg::S_STORE: if (r_v1 && r_last1) n_state = npc_pkg::S_DONE;
            npc_pkg::S_DONE:  n_state = npc_pkg::S_COLLECT;
            default:          n_state = npc_pkg::S_COLLECT;
        endcase
    end

    always_comb begin
        o_ready = (r_state == npc_pkg::S_COLLECT) && !r_ovalid;
        vb_we = w_in_fire && (r_ecnt < w_len);
        vb_waddr = r_ecnt[npc_pkg::DW-1:0];
        vb_wdata = i_element;
        vb_raddr = r_i;
        pm_raddr = {r_p, r_i};
        pm_we = (r_state == npc_pkg::S_STORE) && r_v1;
        pm_waddr = {r_used[npc_pkg::PW-1:0], r_i1};
        pm_wdata = w_a;
        n_v1 = (r_state == npc_pkg::S_SCAN)
            || ((r_state == npc_pkg::S_STORE) && !(r_v1 && r_last1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= npc_pkg::S_COLLECT;
            r_len_reg <= 7'd64;
            r_cap_reg <= 7'd64;
            r_thr <= npc_pkg::SW'(4194304);
            r_used <= '0;
            r_ecnt <= '0;
            r_i <= '0;
            r_p <= '0;
            r_v1 <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    npc_pkg::REG_LEN: r_len_reg <= i_cfg_data[6:0];
                    npc_pkg::REG_CAP: r_cap_reg <= i_cfg_data[6:0];
                    npc_pkg::REG_THR: r_thr <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_state == npc_pkg::S_DONE) begin
                r_ovalid <= 1'b1;
            end else if (o_valid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            r_v1 <= n_v1;
            case (r_state)
                npc_pkg::S_COLLECT: begin
                    if (vb_we) r_ecnt <= r_ecnt + 1'b1;
                    r_i <= '0;
                    r_p <= '0;
                end
                npc_pkg::S_SCAN: begin
                    if (r_i == npc_pkg::DW'(w_len - 1'b1)) begin
                        r_i <= '0;
                        r_p <= r_p + 1'b1;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                npc_pkg::S_DRAIN: begin
                    r_i <= '0;
                    r_p <= '0;
                end
                npc_pkg::S_STORE: begin
                    if (!(r_v1 && r_last1)) begin
                        r_i <= (r_i == npc_pkg::DW'(w_len - 1'b1)) ? r_i : r_i + 1'b1;
                    end
                end
                npc_pkg::S_DONE: begin
                    r_ecnt <= '0;
                    if (w_ins) r_used <= r_used + 1'b1;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_i1 <= r_i;
        r_p1 <= r_p;
        r_first1 <= (r_p == '0);
        r_last1 <= (r_i == npc_pkg::DW'(w_len - 1'b1));
        r_ok1 <= npc_pkg::LW'(r_i) < r_ecnt;
        if (r_state == npc_pkg::S_DONE) begin
            r_onew <= w_ins;
            r_oidx <= 6'(w_ins ? npc_pkg::PW'(r_used) : w_best_slot);
            r_odist <= w_ins ? '0 : w_best;
        end
    end

    assign o_valid = r_ovalid;
    assign o_proto_index = r_oidx;
    assign o_new_proto = r_onew;
    assign o_match_distance_sq = r_odist;
endmodule

// ----- src/npc_checker.sv -----
// Port-level checker for the nearest prototype classifier, with its bind.
// Depends on nothing but the top-level ports.
module npc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_ready,
    input logic        o_valid,
    input logic        i_ready,
    input logic        o_new_proto,
    input logic [38:0] o_match_distance_sq
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_match_distance_sq))
        else $error("result dropped while stalled");
    a_new_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_new_proto |-> o_match_distance_sq == 39'd0)
        else $error("new prototype with nonzero distance");
    a_no_in_while_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready)
        else $error("input taken while result waits");
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result valid after reset");
endmodule

bind nearest_prototype_classifier npc_checker u_npc_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_new_proto(o_new_proto),
    .o_match_distance_sq(o_match_distance_sq)
);
